>>> hdl/irmgf_pkg.sv
// Package for the IR message receiver with gap framing.
// Types, sizes and codes shared by every module of the block; depends on nothing.
package irmgf_pkg;

  localparam int MESSAGE_DEPTH = 64;
  localparam int SAMPLE_DEPTH  = 200;

  localparam int MSG_AW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
  localparam int MSG_CW = $clog2(MESSAGE_DEPTH + 1);
  localparam int SMP_AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int SMP_CW = $clog2(SAMPLE_DEPTH + 1);

  localparam logic [7:0] GAP_LIMIT_RESET = 8'd4;
  localparam logic [7:0] CHAR_MISSING    = 8'hFF;
  localparam logic [7:0] IDLE_MAX        = 8'hFF;
  localparam int         ADC_SHIFT       = 2;

  typedef enum logic [2:0] {
    FN_BYTE        = 3'd0,
    FN_TICK        = 3'd1,
    FN_ADC         = 3'd2,
    FN_RESET       = 3'd3,
    FN_READ_CHAR   = 3'd4,
    FN_READ_SAMPLE = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    RD_ZERO    = 2'd0,
    RD_CHAR    = 2'd1,
    RD_SAMPLE  = 2'd2,
    RD_MISSING = 2'd3
  } rd_sel_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  rx_byte;
    logic [9:0]  adc_value;
    logic [7:0]  char_index;
  } item_t;

  typedef struct packed {
    rd_sel_t           rd_sel;
    logic              read_refused;
    logic              start_conversion;
    logic [MSG_CW-1:0] message_length;
    logic              message_full;
    logic              sampling_busy;
    logic [SMP_CW-1:0] samples_taken;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [MSG_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [MSG_AW-1:0] raddr;
  } msg_req_t;

  typedef struct packed {
    logic              we;
    logic [SMP_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [SMP_AW-1:0] raddr;
  } smp_req_t;

endpackage

>>> hdl/irmgf_msg_mem.sv
// Message byte store: one write and one registered read per cycle.
// Depends on irmgf_pkg.
module irmgf_msg_mem import irmgf_pkg::*; (
  input  logic       clk,
  input  msg_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] mem [MESSAGE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

>>> hdl/irmgf_smp_mem.sv
// Light sample store with per-entry valid bits; unwritten entries read as zero.
// Depends on irmgf_pkg.
module irmgf_smp_mem import irmgf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  smp_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0]              mem [SAMPLE_DEPTH];
  logic [SAMPLE_DEPTH-1:0] valid;
  logic [7:0]              q;
  logic                    q_valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      q <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      q_valid <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        q_valid <= valid[req.raddr];
      end
    end
  end

  assign rdata = q_valid ? q : 8'd0;

endmodule

>>> hdl/irmgf_ctrl.sv
// Receiver state, gap counter, sampling control and store requests for one request.
// Depends on irmgf_pkg.
module irmgf_ctrl import irmgf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic     advance,
  input  item_t    item,
  output result_t  res,
  output msg_req_t msg_req,
  output smp_req_t smp_req
);

  localparam logic [MSG_CW-1:0] MSG_DEPTH_C = MSG_CW'(MESSAGE_DEPTH);
  localparam logic [SMP_CW-1:0] SMP_DEPTH_C = SMP_CW'(SAMPLE_DEPTH);
  localparam logic [SMP_AW-1:0] SMP_LAST_C  = SMP_AW'(SAMPLE_DEPTH - 1);

  logic [7:0]        gap_limit;
  logic [MSG_CW-1:0] msg_count, msg_count_next;
  logic              full_flag, full_flag_next;
  logic              start_pending, start_pending_next;
  logic              sampling_on, sampling_on_next;
  logic [7:0]        idle_ticks, idle_ticks_next;
  logic [SMP_CW-1:0] smp_count, smp_count_next;
  logic [SMP_AW-1:0] rd_ptr, rd_ptr_next;
  logic [MSG_CW-1:0] base;

  always_comb begin
    msg_count_next     = msg_count;
    full_flag_next     = full_flag;
    start_pending_next = start_pending;
    sampling_on_next   = sampling_on;
    idle_ticks_next    = idle_ticks;
    smp_count_next     = smp_count;
    rd_ptr_next        = rd_ptr;
    base               = sampling_on ? msg_count : '0;
    msg_req            = '0;
    smp_req            = '0;
    res.rd_sel           = RD_ZERO;
    res.read_refused     = 1'b0;
    res.start_conversion = 1'b0;
    case (item.func)
      FN_BYTE: begin
        if (!full_flag) begin
          idle_ticks_next = '0;
          if (!sampling_on) begin
            start_pending_next = 1'b1;
          end
          msg_count_next = base;
          if (base < MSG_DEPTH_C) begin
            msg_req.we     = 1'b1;
            msg_req.waddr  = base[MSG_AW-1:0];
            msg_req.wdata  = item.rx_byte;
            msg_count_next = base + 1'b1;
          end
          if (msg_count_next >= MSG_DEPTH_C) begin
            full_flag_next = 1'b1;
          end
        end
      end
      FN_TICK: begin
        if (start_pending && !sampling_on) begin
          start_pending_next = 1'b0;
          sampling_on_next   = 1'b1;
          smp_count_next     = '0;
        end
        if (sampling_on_next) begin
          if (idle_ticks != IDLE_MAX) begin
            idle_ticks_next = idle_ticks + 1'b1;
          end
          if (idle_ticks_next > gap_limit) begin
            full_flag_next = 1'b1;
          end
          res.start_conversion = 1'b1;
        end
      end
      FN_ADC: begin
        if (sampling_on) begin
          if (smp_count < SMP_DEPTH_C) begin
            smp_req.we     = 1'b1;
            smp_req.waddr  = smp_count[SMP_AW-1:0];
            smp_req.wdata  = item.adc_value[ADC_SHIFT +: 8];
            smp_count_next = smp_count + 1'b1;
          end
          if (smp_count_next >= SMP_DEPTH_C) begin
            sampling_on_next = 1'b0;
            full_flag_next   = 1'b1;
          end
        end
      end
      FN_RESET: begin
        full_flag_next     = 1'b0;
        msg_count_next     = '0;
        start_pending_next = 1'b0;
        sampling_on_next   = 1'b0;
      end
      FN_READ_CHAR: begin
        if (9'(item.char_index) < 9'(msg_count)) begin
          msg_req.re    = 1'b1;
          msg_req.raddr = item.char_index[MSG_AW-1:0];
          res.rd_sel    = RD_CHAR;
        end else begin
          res.rd_sel = RD_MISSING;
        end
      end
      FN_READ_SAMPLE: begin
        if (sampling_on) begin
          res.read_refused = 1'b1;
        end else begin
          smp_req.re    = 1'b1;
          smp_req.raddr = rd_ptr;
          res.rd_sel    = RD_SAMPLE;
          rd_ptr_next   = (rd_ptr == SMP_LAST_C) ? '0 : rd_ptr + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!advance) begin
      msg_req.we = 1'b0;
      msg_req.re = 1'b0;
      smp_req.we = 1'b0;
      smp_req.re = 1'b0;
    end
    res.message_length = msg_count_next;
    res.message_full   = full_flag_next;
    res.sampling_busy  = sampling_on_next;
    res.samples_taken  = smp_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit     <= GAP_LIMIT_RESET;
      msg_count     <= '0;
      full_flag     <= 1'b0;
      start_pending <= 1'b0;
      sampling_on   <= 1'b0;
      idle_ticks    <= '0;
      smp_count     <= '0;
      rd_ptr        <= '0;
    end else begin
      if (cfg_we) begin
        gap_limit <= cfg_wdata;
      end
      if (advance) begin
        msg_count     <= msg_count_next;
        full_flag     <= full_flag_next;
        start_pending <= start_pending_next;
        sampling_on   <= sampling_on_next;
        idle_ticks    <= idle_ticks_next;
        smp_count     <= smp_count_next;
        rd_ptr        <= rd_ptr_next;
      end
    end
  end

endmodule

>>> hdl/ir_message_receiver_gap_framer_top.sv
// IR message receiver with idle-gap framing: input register, control, stores, result register.
// Depends on irmgf_pkg, irmgf_ctrl, irmgf_msg_mem and irmgf_smp_mem.

// Takes one request per clock cycle while s_tready is high and returns exactly one result per
// request; the request waits in the input register until the result register is free or
// m_tready is high, and its result is then registered and taken when m_tready is high. Each
// request does at most one write or one read in the message or sample store.
// Sample store entries are cleared at reset through valid bits, so no clearing pass
// is needed. s_tready drops only when both registers are full and m_tready is low.
module ir_message_receiver_gap_framer_top import irmgf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // rx_byte[7:0], adc_value[17:8], char_index[25:18], zero
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // read_data[7:0], read_refused[8], start_conversion[9],
                                 // message_length[16:10], message_full[17],
                                 // sampling_busy[18], samples_taken[26:19], zero
);

  item_t      item;
  logic       item_valid;
  logic       res_valid;
  logic       advance;
  result_t    res_d, res_q;
  msg_req_t   msg_req;
  smp_req_t   smp_req;
  logic [7:0] msg_rdata;
  logic [7:0] smp_rdata;
  logic [7:0] read_data;

  assign advance  = item_valid && (!res_valid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (s_tready) begin
        item_valid <= s_tvalid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.func       <= func_t'(s_tuser);
      item.rx_byte    <= s_tdata[7:0];
      item.adc_value  <= s_tdata[17:8];
      item.char_index <= s_tdata[25:18];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  irmgf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (item),
    .res       (res_d),
    .msg_req   (msg_req),
    .smp_req   (smp_req)
  );

  irmgf_msg_mem u_msg_mem (
    .clk   (clk),
    .req   (msg_req),
    .rdata (msg_rdata)
  );

  irmgf_smp_mem u_smp_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (smp_req),
    .rdata (smp_rdata)
  );

  always_comb begin
    case (res_q.rd_sel)
      RD_CHAR:    read_data = msg_rdata;
      RD_SAMPLE:  read_data = smp_rdata;
      RD_MISSING: read_data = CHAR_MISSING;
      default:    read_data = 8'd0;
    endcase
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {5'd0,
                     8'(res_q.samples_taken),
                     res_q.sampling_busy,
                     res_q.message_full,
                     7'(res_q.message_length),
                     res_q.start_conversion,
                     res_q.read_refused,
                     read_data};

endmodule
